// ===== hw/rtl/fmbq_pkg.sv =====
// fmbq_pkg: shared types, constants and pointer helpers of the front/middle/back queue
`default_nettype none

package fmbq_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned EXT_W    = 64;

  localparam int unsigned IN_RAW_W   = REQ_W + VAL_W;
  localparam int unsigned IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W  = STATUS_W + VAL_W + FILL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_MID   = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_MID    = 3'd4,
    REQ_POP_BACK   = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_BAL,
    S_MOVE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic latch;
    logic do_op;
    logic do_bal;
    logic do_move;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bal_need;
    logic out_free;
  } sts_t;

  // ring pointer plus offset, offset never above DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] p,
                                                 logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == '0) begin
      r = ADDR_W'(DEPTH - 1);
    end else begin
      r = p - ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fmbq_ram.sv =====
// fmbq_ram: generic single write, single read ram with registered read data
`default_nettype none

module fmbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fmbq_ctrl.sv =====
// fmbq_ctrl: request sequencer of the queue
`default_nettype none

module fmbq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire fmbq_pkg::sts_t sts_i,
  output fmbq_pkg::cmd_t     cmd_o
);

  fmbq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmbq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmbq_pkg::S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = fmbq_pkg::S_OP;
        end
      end
      fmbq_pkg::S_OP: begin
        state_d = fmbq_pkg::S_BAL;
      end
      fmbq_pkg::S_BAL: begin
        state_d = sts_i.bal_need ? fmbq_pkg::S_MOVE : fmbq_pkg::S_FIN;
      end
      fmbq_pkg::S_MOVE: begin
        state_d = fmbq_pkg::S_FIN;
      end
      fmbq_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          state_d = fmbq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fmbq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      fmbq_pkg::S_IDLE: begin
        s_tready_o  = 1'b1;
        cmd_o.latch = s_tvalid_i;
      end
      fmbq_pkg::S_OP: begin
        cmd_o.do_op = 1'b1;
      end
      fmbq_pkg::S_BAL: begin
        cmd_o.do_bal = 1'b1;
      end
      fmbq_pkg::S_MOVE: begin
        cmd_o.do_move = 1'b1;
      end
      fmbq_pkg::S_FIN: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fmbq_dp.sv =====
// fmbq_dp: two ring-buffer halves (front half, back half), pointers and result register
`default_nettype none

module fmbq_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fmbq_pkg::cmd_t                    cmd_i,
  output fmbq_pkg::sts_t                         sts_o,
  input  wire logic [fmbq_pkg::IN_DATA_W-1:0]    s_tdata_i,
  input  wire logic                              m_tready_i,
  output logic                                   m_tvalid_o,
  output logic      [fmbq_pkg::OUT_DATA_W-1:0]   m_tdata_o
);

  localparam int unsigned AW = fmbq_pkg::ADDR_W;
  localparam int unsigned CW = fmbq_pkg::CNT_W;
  localparam int unsigned WB = fmbq_pkg::WORD_BITS;

  // latched request
  logic [fmbq_pkg::REQ_W-1:0] req_q, req_d;
  logic [WB-1:0]              val_q, val_d;

  // front half holds the first fc words, back half the rest
  logic [AW-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CW-1:0] fc_q, fc_d, bc_q, bc_d;

  logic                          pop_q, pop_d;
  logic                          pop_src_q, pop_src_d;
  logic                          to_b_q, to_b_d;
  logic [fmbq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [WB-1:0]                 pop_data_q, pop_data_d;

  logic                            out_valid_q, out_valid_d;
  logic [fmbq_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic          f_we, b_we;
  logic [AW-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
  logic [WB-1:0] f_wdata, b_wdata, f_rdata, b_rdata;

  logic [CW-1:0] n, target;
  logic          full, empty;
  logic [AW-1:0] f_prev, f_tail, f_last, b_prev, b_next, b_tail, b_last;
  logic [fmbq_pkg::EXT_W-1:0]    ext;
  logic [fmbq_pkg::VAL_W-1:0]    out_val;
  logic                          out_free;

  assign n      = fc_q + bc_q;
  assign target = n >> 1;
  assign full   = (n == CW'(fmbq_pkg::DEPTH));
  assign empty  = (n == '0);

  assign f_prev = fmbq_pkg::wrap_dec(fh_q);
  assign f_tail = fmbq_pkg::wrap_add(fh_q, fc_q);
  assign f_last = fmbq_pkg::wrap_add(fh_q, fc_q - CW'(1));
  assign b_prev = fmbq_pkg::wrap_dec(bh_q);
  assign b_next = fmbq_pkg::wrap_add(bh_q, CW'(1));
  assign b_tail = fmbq_pkg::wrap_add(bh_q, bc_q);
  assign b_last = fmbq_pkg::wrap_add(bh_q, bc_q - CW'(1));

  assign out_free       = !out_valid_q || m_tready_i;
  assign sts_o.out_free = out_free;
  assign sts_o.bal_need = (fc_q != target);

  assign ext = fmbq_pkg::EXT_W'($signed(pop_data_q));

  always_comb begin
    if (status_q == fmbq_pkg::ST_EMPTY) begin
      out_val = '1;
    end else if (pop_q) begin
      out_val = ext[fmbq_pkg::VAL_W-1:0];
    end else begin
      out_val = '0;
    end
  end

  always_comb begin
    req_d       = req_q;
    val_d       = val_q;
    fh_d        = fh_q;
    fc_d        = fc_q;
    bh_d        = bh_q;
    bc_d        = bc_q;
    pop_d       = pop_q;
    pop_src_d   = pop_src_q;
    to_b_d      = to_b_q;
    status_d    = status_q;
    pop_data_d  = pop_data_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_tready_i;
    f_we        = 1'b0;
    f_waddr     = f_tail;
    f_wdata     = val_q;
    f_raddr     = f_last;
    b_we        = 1'b0;
    b_waddr     = b_tail;
    b_wdata     = val_q;
    b_raddr     = bh_q;

    if (cmd_i.latch) begin
      req_d = s_tdata_i[fmbq_pkg::REQ_W-1:0];
      val_d = WB'(s_tdata_i[fmbq_pkg::REQ_W +: fmbq_pkg::VAL_W]);
    end

    if (cmd_i.do_op) begin
      status_d = fmbq_pkg::ST_DONE;
      pop_d    = 1'b0;
      unique case (req_q) inside
        fmbq_pkg::REQ_PUSH_FRONT,
        fmbq_pkg::REQ_PUSH_MID,
        fmbq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            status_d = fmbq_pkg::ST_FULL;
          end else if (req_q == fmbq_pkg::REQ_PUSH_FRONT) begin
            f_we    = 1'b1;
            f_waddr = f_prev;
            fh_d    = f_prev;
            fc_d    = fc_q + CW'(1);
          end else if (req_q == fmbq_pkg::REQ_PUSH_MID && n[0]) begin
            // odd count: the middle slot is just past the front half
            f_we    = 1'b1;
            f_waddr = f_tail;
            fc_d    = fc_q + CW'(1);
          end else if (req_q == fmbq_pkg::REQ_PUSH_MID) begin
            b_we    = 1'b1;
            b_waddr = b_prev;
            bh_d    = b_prev;
            bc_d    = bc_q + CW'(1);
          end else begin
            b_we    = 1'b1;
            b_waddr = b_tail;
            bc_d    = bc_q + CW'(1);
          end
        end
        fmbq_pkg::REQ_POP_FRONT,
        fmbq_pkg::REQ_POP_MID,
        fmbq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            status_d = fmbq_pkg::ST_EMPTY;
          end else begin
            pop_d = 1'b1;
            if ((req_q == fmbq_pkg::REQ_POP_FRONT && fc_q != '0) ||
                (req_q == fmbq_pkg::REQ_POP_MID && !n[0])) begin
              pop_src_d = 1'b0;
              if (req_q == fmbq_pkg::REQ_POP_FRONT) begin
                f_raddr = fh_q;
                fh_d    = fmbq_pkg::wrap_add(fh_q, CW'(1));
              end else begin
                f_raddr = f_last;
              end
              fc_d = fc_q - CW'(1);
            end else begin
              // single word left, odd middle, or back: taken from the back half
              pop_src_d = 1'b1;
              if (req_q == fmbq_pkg::REQ_POP_BACK) begin
                b_raddr = b_last;
              end else begin
                b_raddr = bh_q;
                bh_d    = b_next;
              end
              bc_d = bc_q - CW'(1);
            end
          end
        end
        default: begin
          status_d = fmbq_pkg::ST_DONE;
        end
      endcase
    end

    if (cmd_i.do_bal) begin
      if (pop_q) begin
        pop_data_d = pop_src_q ? b_rdata : f_rdata;
      end
      if (fc_q > target) begin
        to_b_d  = 1'b1;
        f_raddr = f_last;
        fc_d    = fc_q - CW'(1);
      end else if (fc_q < target) begin
        to_b_d  = 1'b0;
        b_raddr = bh_q;
        bh_d    = b_next;
        bc_d    = bc_q - CW'(1);
      end
    end

    if (cmd_i.do_move) begin
      if (to_b_q) begin
        b_we    = 1'b1;
        b_waddr = b_prev;
        b_wdata = f_rdata;
        bh_d    = b_prev;
        bc_d    = bc_q + CW'(1);
      end else begin
        f_we    = 1'b1;
        f_waddr = f_tail;
        f_wdata = b_rdata;
        fc_d    = fc_q + CW'(1);
      end
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = fmbq_pkg::OUT_DATA_W'({fmbq_pkg::FILL_W'(n), out_val, status_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q        <= '0;
      fc_q        <= '0;
      bh_q        <= '0;
      bc_q        <= '0;
      pop_q       <= 1'b0;
      status_q    <= fmbq_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      fh_q        <= fh_d;
      fc_q        <= fc_d;
      bh_q        <= bh_d;
      bc_q        <= bc_d;
      pop_q       <= pop_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    val_q      <= val_d;
    pop_src_q  <= pop_src_d;
    to_b_q     <= to_b_d;
    pop_data_q <= pop_data_d;
    out_data_q <= out_data_d;
  end

  fmbq_ram #(
    .WIDTH (WB),
    .DEPTH (fmbq_pkg::DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  fmbq_ram #(
    .WIDTH (WB),
    .DEPTH (fmbq_pkg::DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // halves are balanced whenever a new word is taken
  a_balanced_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch |-> (fc_q == target))
    else $error("queue halves out of balance at accept");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten while held");

  a_move_follows_bal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_move |-> ($past(cmd_i.do_bal) && $past(sts_o.bal_need)))
    else $error("move step without a rebalance request");

  a_empty_pop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_op && empty && (req_q == fmbq_pkg::REQ_POP_FRONT ||
      req_q == fmbq_pkg::REQ_POP_MID || req_q == fmbq_pkg::REQ_POP_BACK))
    |=> (status_q == fmbq_pkg::ST_EMPTY))
    else $error("pop on empty queue not flagged");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/front_middle_back_queue.sv =====
// front_middle_back_queue: one word in, one result word out for each accepted word
// each word passes a request step, a read step, an optional half-rebalance move step and a result load
// a new word is taken only once the result of the last one is loaded into the result register
// the result register lets the next word be taken while a result waits on the master side
// reset (rst_ni low, asynchronous) empties the queue; storage contents are not cleared
`default_nettype none

module front_middle_back_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] req_type, [34:3] push_value, rest zero
  input  wire logic [fmbq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] status, [33:2] pop_value, [40:34] fill_level, rest zero
  output logic      [fmbq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  fmbq_pkg::cmd_t cmd;
  fmbq_pkg::sts_t sts;

  fmbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmbq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== bench/fmbq_checker.sv =====
// fmbq_checker: watches both stream channels, predicts each result word and compares it
module fmbq_checker
  import fmbq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  input  wire logic [OUT_DATA_W-1:0] m_tdata_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
    logic [FILL_W-1:0]   fill;
  } outcome_t;

  // shadow of the queue contents, index 0 is the front
  logic [WORD_BITS-1:0] shadow_q[$];
  outcome_t             outcome_q[$];
  outcome_t             want;
  outcome_t             got;
  int unsigned          fails   = 0;
  int unsigned          waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    $display("mismatch at %0t: %s expected %h got %h", $time, what, want_v, got_v);
    fails++;
  endtask

  task automatic serve_request(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] word,
                               output outcome_t res);
    int unsigned pos;
    int unsigned held;
    held       = shadow_q.size();
    res.status = ST_DONE;
    res.value  = '0;
    pos        = 0;
    case (kind) inside
      REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (kind == REQ_PUSH_MID) begin
            pos = held / 2;
          end else if (kind == REQ_PUSH_BACK) begin
            pos = held;
          end
          shadow_q.insert(pos, word[WORD_BITS-1:0]);
        end
      end
      REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
          res.value  = '1;
        end else begin
          if (kind == REQ_POP_MID) begin
            pos = (held - 1) / 2;
          end else if (kind == REQ_POP_BACK) begin
            pos = held - 1;
          end
          res.value = VAL_W'($signed(shadow_q[pos]));
          shadow_q.delete(pos);
        end
      end
      default: begin
        // unused kinds leave the queue alone
      end
    endcase
    res.fill = FILL_W'(shadow_q.size());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got.status = m_tdata_i[STATUS_W-1:0];
        got.value  = m_tdata_i[STATUS_W +: VAL_W];
        got.fill   = m_tdata_i[STATUS_W+VAL_W +: FILL_W];
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result word", '0, 64'(m_tdata_i));
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(got.status));
          end
          if (got.value !== want.value) begin
            report_mismatch("pop_value", 64'(want.value), 64'(got.value));
          end
          if (got.fill !== want.fill) begin
            report_mismatch("fill_level", 64'(want.fill), 64'(got.fill));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        serve_request(s_tdata_i[REQ_W-1:0], s_tdata_i[REQ_W +: VAL_W], want);
        outcome_q.insert(outcome_q.size(), want);
      end
      waiting = outcome_q.size();
    end
  end

endmodule

// ===== bench/tb_front_middle_back_queue.sv =====
// tb_front_middle_back_queue: stimulus, reset, watchdog and verdict for the queue block
module tb_front_middle_back_queue;
  import fmbq_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1150;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned KIND_TOP     = (1 << REQ_W) - 1;

  typedef enum int unsigned {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED
  } mix_e;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           idle_cycles   = 0;
  bit                    calm          = 1'b0;

  always #6 clk = ~clk;

  front_middle_back_queue u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fmbq_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result side: a fresh random stall, which may be zero, before every word outside calm phases
  initial begin
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // tvalid is touched only here and in drain_results, so a gapless next word keeps it high
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] word);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({word, kind});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = {1'b0, {(VAL_W-1){1'b1}}};
      3:       v = {1'b1, {(VAL_W-1){1'b0}}};
      default: v = VAL_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input mix_e mode);
    int unsigned roll;
    int unsigned push_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mode == MODE_GROW) ? 88 : (mode == MODE_SHRINK) ? 12 : 50;
    if (roll < 3) begin
      return REQ_W'($urandom_range(REQ_POP_BACK + 1, KIND_TOP));
    end else if ($urandom_range(0, 99) < push_pct) begin
      return REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_BACK));
    end
    return REQ_W'($urandom_range(REQ_POP_FRONT, REQ_POP_BACK));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned phase;
    mix_e        mode;
    sent  = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops on every side
    send_word(REQ_POP_FRONT, '0);
    send_word(REQ_POP_MID, '1);
    send_word(REQ_POP_BACK, '0);
    // extremes on every push side
    send_word(REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_word(REQ_PUSH_BACK, 32'h8000_0000);
    send_word(REQ_PUSH_MID, 32'hffff_ffff);
    send_word(REQ_PUSH_MID, 32'h0000_0000);
    send_word(REQ_PUSH_FRONT, 32'h0000_0001);
    send_word(REQ_PUSH_MID, 32'h5555_aaaa);
    // unused kinds must leave the queue alone
    send_word(REQ_W'(REQ_POP_BACK + 1), 32'hdead_beef);
    send_word(REQ_W'(KIND_TOP), 32'hffff_ffff);
    send_word(REQ_POP_MID, '0);
    send_word(REQ_POP_MID, '0);
    send_word(REQ_POP_FRONT, '0);
    send_word(REQ_POP_BACK, '0);
    send_word(REQ_POP_MID, '0);
    send_word(REQ_POP_MID, '0);
    send_word(REQ_POP_BACK, '0);
    drain_results();

    // grow and shrink phases so the queue reaches full and empty repeatedly
    while (sent < RANDOM_WORDS) begin
      if (phase == 0) begin
        mode = MODE_GROW;
        span = 110;
      end else if (phase == 1) begin
        mode = MODE_SHRINK;
        span = 110;
      end else begin
        mode = mix_e'($urandom_range(MODE_GROW, MODE_MIXED));
        span = $urandom_range(20, 90);
      end
      if (span > RANDOM_WORDS - sent) begin
        span = RANDOM_WORDS - sent;
      end
      calm = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        send_word(pick_kind(mode), pick_value());
        sent++;
      end
      if (phase == 0 || $urandom_range(0, 3) == 0) begin
        drain_results();
      end
      phase++;
    end

    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== front_middle_back_queue.f =====
hw/rtl/fmbq_pkg.sv
hw/rtl/fmbq_ram.sv
hw/rtl/fmbq_ctrl.sv
hw/rtl/fmbq_dp.sv
hw/rtl/front_middle_back_queue.sv
bench/fmbq_checker.sv
bench/tb_front_middle_back_queue.sv
